@@ rtl/mfq_pkg.sv @@
// Shared types and constants for the multilevel feedback queue scheduler.
// No dependencies; every other file of the block uses this package.
package mfq_pkg;

   // Field widths of the channel words
   localparam int MODE_BITS     = 1;
   localparam int JOB_ID_BITS   = 4;
   localparam int LENGTH_BITS   = 16;
   localparam int STATUS_BITS   = 2;
   localparam int LEVEL_BITS    = 2;
   localparam int SERVED_BITS   = 16;
   localparam int CSR_DATA_BITS = 8;
   localparam int RUN_BITS      = 8;

   // Input word kinds
   localparam logic [MODE_BITS-1:0] MODE_ADD  = 1'b0;
   localparam logic [MODE_BITS-1:0] MODE_TICK = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_ADD_OK     = 2'd0,
      STATUS_ADD_REJECT = 2'd1,
      STATUS_TICK_RAN   = 2'd2,
      STATUS_TICK_IDLE  = 2'd3
   } status_type;

   // Queue levels
   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE   = 2'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_TWO   = 2'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_THREE = 2'd2;

   // Configuration register indexes and reset values
   localparam logic CSR_QUANTUM_TWO   = 1'b0;
   localparam logic CSR_QUANTUM_THREE = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0] QUANTUM_TWO_RESET   = 8'd2;
   localparam logic [CSR_DATA_BITS-1:0] QUANTUM_THREE_RESET = 8'd4;

   localparam logic [RUN_BITS-1:0] RUN_COUNT_MAX = 8'hFF;

   // Per-queue update for one cycle: pop the front, re-append the old front,
   // append a given id (appended after the re-appended front).
   typedef struct packed {
      logic pop;
      logic push_front;
      logic push_id;
   } queue_ctrl_type;

   // Job table update for one cycle
   typedef struct packed {
      logic add;
      logic serve;
   } job_ctrl_type;

endpackage

@@ rtl/mfq_if.sv @@
// Valid/ready channel interfaces for the scheduler's request and response words.
// Depends on mfq_pkg for field widths.
interface mfq_req_if;
   logic                               valid;
   logic                               ready;
   logic [mfq_pkg::MODE_BITS-1:0]      mode;
   logic [mfq_pkg::JOB_ID_BITS-1:0]    job_id;
   logic [mfq_pkg::LENGTH_BITS-1:0]    run_length;

   modport source (output valid, mode, job_id, run_length, input ready);
   modport sink   (input valid, mode, job_id, run_length, output ready);
endinterface

interface mfq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mfq_pkg::STATUS_BITS-1:0]    status;
   logic [mfq_pkg::JOB_ID_BITS-1:0]    ran_job;
   logic [mfq_pkg::LEVEL_BITS-1:0]     ran_level;
   logic                               job_finished;
   logic [mfq_pkg::SERVED_BITS-1:0]    served_time;

   modport source (output valid, status, ran_job, ran_level, job_finished, served_time,
                   input ready);
   modport sink   (input valid, status, ran_job, ran_level, job_finished, served_time,
                   output ready);
endinterface

@@ rtl/mfq_queue.sv @@
// Circular queue of job ids for one scheduler level.
// Depends on mfq_pkg (queue_ctrl_type).
module mfq_queue #(
   parameter int MAX_JOBS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mfq_pkg::queue_ctrl_type ctrl,
   input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] push_id,
   output logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] front_id,
   output logic                    nonempty
);

   localparam int IDW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW  = $clog2(MAX_JOBS + 1);
   localparam int SW  = IDW + 2;

   logic [IDW-1:0] slot_ff [MAX_JOBS];
   logic [IDW-1:0] head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;

   logic [SW-1:0]  sum_a, sum_b;
   logic [IDW-1:0] tail_a, tail_b;

   assign front_id = slot_ff[head_ff];
   assign nonempty = (count_ff != '0);

   // Tail slots; head + count stays below twice the depth, one subtract wraps it
   always_comb begin
      sum_a  = SW'(head_ff) + SW'(count_ff);
      tail_a = (sum_a >= SW'(MAX_JOBS)) ? IDW'(sum_a - SW'(MAX_JOBS)) : IDW'(sum_a);
      sum_b  = SW'(tail_a) + SW'(ctrl.push_front);
      tail_b = (sum_b >= SW'(MAX_JOBS)) ? IDW'(sum_b - SW'(MAX_JOBS)) : IDW'(sum_b);
   end

   always_comb begin
      head_in = head_ff;
      if (ctrl.pop) begin
         head_in = (head_ff == IDW'(MAX_JOBS - 1)) ? '0 : head_ff + 1'b1;
      end
      count_in = count_ff + CW'(ctrl.push_front) + CW'(ctrl.push_id) - CW'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push_front) begin
         slot_ff[tail_a] <= front_id;
      end
      if (ctrl.push_id) begin
         slot_ff[tail_b] <= push_id;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> nonempty)
      else $error("queue popped while empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push_front || ctrl.push_id) |->
         (int'(count_ff) + int'(ctrl.push_front) + int'(ctrl.push_id)
          - int'(ctrl.pop) <= MAX_JOBS))
      else $error("queue overflow");

endmodule

@@ rtl/mfq_jobs.sv @@
// Job table: active flags, needed and used time per job slot.
// Depends on mfq_pkg (job_ctrl_type).
module mfq_jobs #(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mfq_pkg::job_ctrl_type ctrl,
   input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] add_id,
   input  logic [TIME_BITS-1:0]  add_len,
   input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] serve_id,
   output logic                  busy,
   output logic [TIME_BITS-1:0]  used_next,
   output logic                  done
);

   logic [MAX_JOBS-1:0]  active_ff;
   logic [TIME_BITS-1:0] needed_ff [MAX_JOBS];
   logic [TIME_BITS-1:0] used_ff   [MAX_JOBS];

   assign busy      = active_ff[add_id];
   assign used_next = used_ff[serve_id] + 1'b1;   // wraps at TIME_BITS
   assign done      = (used_next == needed_ff[serve_id]);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (ctrl.add) begin
         active_ff[add_id] <= 1'b1;
      end else if (ctrl.serve && done) begin
         active_ff[serve_id] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.add) begin
         needed_ff[add_id] <= add_len;
         used_ff[add_id]   <= '0;
      end else if (ctrl.serve) begin
         used_ff[serve_id] <= used_next;
      end
   end

   a_serve_active: assert property (@(posedge clock) disable iff (reset)
      ctrl.serve |-> active_ff[serve_id])
      else $error("served job slot is not active");

endmodule

@@ rtl/multilevel_feedback_queue_scheduler_unit.sv @@
// Top level of the three-level feedback queue scheduler.
// Depends on mfq_pkg, mfq_if (mfq_req_if, mfq_rsp_if), mfq_queue and mfq_jobs.
//
// Usage:
//   req_chan carries one word per item: mode 0 adds job job_id with run_length
//   ticks at the tail of level one; mode 1 is one time tick. rsp_chan returns
//   exactly one word per request word: status, and for a tick that ran a job
//   the job id, its level, whether it finished and its used time.
//   csr_write_en/csr_index/csr_write_data set the level-two quantum (index 0)
//   and the level-three round robin slice (index 1); write them only while idle.
// Timing:
//   A request word is captured in an input register; once the response
//   register is free or being emptied, the queue and job-table update happens
//   and the result is loaded into the response register, from which the
//   response word is taken. One word per cycle is sustained while rsp_chan.ready
//   stays high: every item touches only the three queue fronts, the queue
//   tails and one job entry, all read and written in the same cycle.
// Reset:
//   Synchronous, active high. All queues empty, no job active, quanta 2 and 4.
// Stall:
//   While rsp_chan.ready is low the response register holds; one more word
//   waits in the input register, then req_chan.ready drops.
module multilevel_feedback_queue_scheduler_unit #(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mfq_req_if.sink                              req_chan,
   mfq_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_en,
   input  logic                                 csr_index,
   input  logic [mfq_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int IDW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

   // Input register
   logic                                in_valid_ff;
   logic [mfq_pkg::MODE_BITS-1:0]       in_mode_ff;
   logic [mfq_pkg::JOB_ID_BITS-1:0]     in_job_id_ff;
   logic [mfq_pkg::LENGTH_BITS-1:0]     in_run_length_ff;

   // Response register
   logic                                rsp_valid_ff;
   mfq_pkg::status_type                 rsp_status_ff,   rsp_status_in;
   logic [mfq_pkg::JOB_ID_BITS-1:0]     rsp_job_ff,      rsp_job_in;
   logic [mfq_pkg::LEVEL_BITS-1:0]      rsp_level_ff,    rsp_level_in;
   logic                                rsp_finished_ff, rsp_finished_in;
   logic [mfq_pkg::SERVED_BITS-1:0]     rsp_served_ff,   rsp_served_in;

   // Quanta
   logic [mfq_pkg::CSR_DATA_BITS-1:0]   quantum_two_ff, quantum_three_ff;

   // Run count of the one job that may hold a partial slice. Only the last
   // served job can have a nonzero count, and it sits at the front of level
   // two or three; rc_l3_ff tells which.
   logic [mfq_pkg::RUN_BITS-1:0]        rc_ff, rc_in;
   logic                                rc_l3_ff, rc_l3_in;

   logic                                proc_fire;
   logic                                is_tick, jid_ok, add_ok, tick_run;
   logic [TIME_BITS-1:0]                add_len;
   logic [IDW-1:0]                      add_idx, serve_id;
   logic [mfq_pkg::LEVEL_BITS-1:0]      lv;
   logic                                serve_one, serve_two, serve_three;
   logic                                rc_nz, rot_two, rot_three;
   logic [mfq_pkg::RUN_BITS-1:0]        cur_rc, new_rc, quantum;
   logic                                reached;

   logic                                busy, done;
   logic [TIME_BITS-1:0]                used_next;
   mfq_pkg::job_ctrl_type               job_ctrl;

   mfq_pkg::queue_ctrl_type             q_ctrl    [3];
   logic [IDW-1:0]                      q_push_id [3];
   logic [IDW-1:0]                      q_front   [3];
   logic [2:0]                          q_ne;

   // ---------------- handshake ----------------
   // The item in the input register is processed once the response register
   // is free or being emptied this cycle.
   assign proc_fire      = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_mode_ff       <= req_chan.mode;
         in_job_id_ff     <= req_chan.job_id;
         in_run_length_ff <= req_chan.run_length;
      end
   end

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_two_ff   <= mfq_pkg::QUANTUM_TWO_RESET;
         quantum_three_ff <= mfq_pkg::QUANTUM_THREE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mfq_pkg::CSR_QUANTUM_TWO:   quantum_two_ff   <= csr_write_data;
            mfq_pkg::CSR_QUANTUM_THREE: quantum_three_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------- decode ----------------
   assign is_tick = (in_mode_ff == mfq_pkg::MODE_TICK);
   assign add_len = TIME_BITS'(in_run_length_ff);
   assign add_idx = IDW'(in_job_id_ff);
   assign jid_ok  = (32'(in_job_id_ff) < MAX_JOBS);
   // busy reads an undefined slot only when jid_ok is low, and then is masked
   assign add_ok  = !is_tick && jid_ok && !busy && (add_len != '0);

   // Highest non-empty level wins
   always_comb begin
      priority if (q_ne[0]) begin
         lv = mfq_pkg::LEVEL_ONE;
      end else if (q_ne[1]) begin
         lv = mfq_pkg::LEVEL_TWO;
      end else begin
         lv = mfq_pkg::LEVEL_THREE;
      end
   end

   always_comb begin
      unique case (lv)
         mfq_pkg::LEVEL_ONE: serve_id = q_front[0];
         mfq_pkg::LEVEL_TWO: serve_id = q_front[1];
         default:            serve_id = q_front[2];
      endcase
   end

   assign tick_run    = is_tick && (q_ne != '0);
   assign serve_one   = tick_run && (lv == mfq_pkg::LEVEL_ONE);
   assign serve_two   = tick_run && (lv == mfq_pkg::LEVEL_TWO);
   assign serve_three = tick_run && (lv == mfq_pkg::LEVEL_THREE);

   // A partly served lower front job is rotated when a higher level runs
   assign rc_nz     = (rc_ff != '0);
   assign rot_two   = is_tick && q_ne[0] && rc_nz && !rc_l3_ff;
   assign rot_three = is_tick && (q_ne[0] || q_ne[1]) && rc_nz && rc_l3_ff;

   always_comb begin
      cur_rc = '0;
      if (rc_nz && ((serve_two && !rc_l3_ff) || (serve_three && rc_l3_ff))) begin
         cur_rc = rc_ff;
      end
      new_rc  = (cur_rc != mfq_pkg::RUN_COUNT_MAX) ? cur_rc + 1'b1 : cur_rc;
      quantum = serve_two ? quantum_two_ff : quantum_three_ff;
      reached = (new_rc >= quantum);   // quantum of zero behaves as one
   end

   // ---------------- queue and table control ----------------
   always_comb begin
      job_ctrl.add   = proc_fire && add_ok;
      job_ctrl.serve = proc_fire && tick_run;

      q_ctrl[0].pop        = proc_fire && serve_one;
      q_ctrl[0].push_front = 1'b0;
      q_ctrl[0].push_id    = proc_fire && add_ok;
      q_push_id[0]         = add_idx;

      q_ctrl[1].pop        = proc_fire && (rot_two || (serve_two && (done || reached)));
      q_ctrl[1].push_front = proc_fire && rot_two;
      q_ctrl[1].push_id    = proc_fire && serve_one && !done;
      q_push_id[1]         = serve_id;

      q_ctrl[2].pop        = proc_fire && (rot_three || (serve_three && (done || reached)));
      q_ctrl[2].push_front = proc_fire && (rot_three || (serve_three && !done && reached));
      q_ctrl[2].push_id    = proc_fire && serve_two && !done && reached;
      q_push_id[2]         = serve_id;
   end

   always_comb begin
      rc_in    = rc_ff;
      rc_l3_in = rc_l3_ff;
      if (proc_fire && tick_run) begin
         if (done || serve_one || reached) begin
            rc_in = '0;
         end else begin
            rc_in    = new_rc;
            rc_l3_in = serve_three;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff    <= '0;
         rc_l3_ff <= 1'b0;
      end else begin
         rc_ff    <= rc_in;
         rc_l3_ff <= rc_l3_in;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_level
      mfq_queue #(
         .MAX_JOBS (MAX_JOBS)
      ) u_queue (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (q_ctrl[g]),
         .push_id  (q_push_id[g]),
         .front_id (q_front[g]),
         .nonempty (q_ne[g])
      );
   end

   mfq_jobs #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS)
   ) u_jobs (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (job_ctrl),
      .add_id    (add_idx),
      .add_len   (add_len),
      .serve_id  (serve_id),
      .busy      (busy),
      .used_next (used_next),
      .done      (done)
   );

   // ---------------- response word ----------------
   always_comb begin
      rsp_job_in      = '0;
      rsp_level_in    = '0;
      rsp_finished_in = 1'b0;
      rsp_served_in   = '0;
      if (!is_tick) begin
         rsp_status_in = add_ok ? mfq_pkg::STATUS_ADD_OK : mfq_pkg::STATUS_ADD_REJECT;
      end else if (!tick_run) begin
         rsp_status_in = mfq_pkg::STATUS_TICK_IDLE;
      end else begin
         rsp_status_in   = mfq_pkg::STATUS_TICK_RAN;
         rsp_job_in      = mfq_pkg::JOB_ID_BITS'(serve_id);
         rsp_level_in    = lv;
         rsp_finished_in = done;
         rsp_served_in   = mfq_pkg::SERVED_BITS'(used_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_job_ff      <= rsp_job_in;
         rsp_level_ff    <= rsp_level_in;
         rsp_finished_ff <= rsp_finished_in;
         rsp_served_ff   <= rsp_served_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.ran_job      = rsp_job_ff;
   assign rsp_chan.ran_level    = rsp_level_ff;
   assign rsp_chan.job_finished = rsp_finished_ff;
   assign rsp_chan.served_time  = rsp_served_ff;

   // ---------------- checks ----------------
   // The partial run count always belongs to a job still queued at its level
   a_rc_owner_queued: assert property (@(posedge clock) disable iff (reset)
      (rc_ff != '0) |-> (rc_l3_ff ? q_ne[2] : q_ne[1]))
      else $error("partial run count with its level empty");

   a_idle_tick_status: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && is_tick && (q_ne == '0)) |=>
         (rsp_chan.valid && rsp_chan.status == mfq_pkg::STATUS_TICK_IDLE))
      else $error("idle tick did not report idle");

endmodule

@@ test/tb_multilevel_feedback_queue_scheduler_unit.sv @@
// Self-checking bench for multilevel_feedback_queue_scheduler_unit: adds and ticks go in,
// results are predicted by a shadow scheduler and compared word by word.
// Depends on mfq_pkg and the mfq_req_if / mfq_rsp_if channel interfaces.
module tb_multilevel_feedback_queue_scheduler_unit;

   localparam int MODE_BITS     = mfq_pkg::MODE_BITS;
   localparam int JOB_ID_BITS   = mfq_pkg::JOB_ID_BITS;
   localparam int LENGTH_BITS   = mfq_pkg::LENGTH_BITS;
   localparam int LEVEL_BITS    = mfq_pkg::LEVEL_BITS;
   localparam int SERVED_BITS   = mfq_pkg::SERVED_BITS;
   localparam int CSR_DATA_BITS = mfq_pkg::CSR_DATA_BITS;
   localparam int RUN_BITS      = mfq_pkg::RUN_BITS;

   localparam int JOB_SLOTS    = 16;
   localparam int IDLE_PERCENT = 32;
   localparam int HOLD_CYCLES  = 80;    // long response hold-off
   localparam int DRAIN_CYCLES = 4;     // drain of the input and response registers plus margin
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all

   typedef struct packed {
      mfq_pkg::status_type       status;
      logic [JOB_ID_BITS-1:0]    job;
      logic [LEVEL_BITS-1:0]     level;
      logic                      finished;
      logic [SERVED_BITS-1:0]    served;
   } sched_result_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_en;
   logic                       csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_write_data;

   mfq_req_if req_chan ();
   mfq_rsp_if rsp_chan ();

   multilevel_feedback_queue_scheduler_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Shadow scheduler: one circular id queue per level plus the job table.
   logic [JOB_ID_BITS-1:0]  lane_slot  [3][JOB_SLOTS];
   int                      lane_head  [3];
   int                      lane_count [3];
   logic                    job_busy   [JOB_SLOTS];
   logic [LENGTH_BITS-1:0]  job_need   [JOB_SLOTS];
   logic [SERVED_BITS-1:0]  job_used   [JOB_SLOTS];
   logic [RUN_BITS-1:0]     job_runs   [JOB_SLOTS];
   logic [CSR_DATA_BITS-1:0] slice_two;
   logic [CSR_DATA_BITS-1:0] slice_three;

   sched_result_type due_results [$];   // expected words, oldest first
   sched_result_type head_result;
   int               errors = 0;
   int               quiet_cycles = 0;
   bit               gaps_on;           // random idling on both channels
   bit               hold_request;      // receiver holds off once, for the long hold-off

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [JOB_ID_BITS-1:0] lane_front(int lv);
      return lane_slot[lv][lane_head[lv]];
   endfunction

   function automatic void lane_pop(int lv);
      lane_head[lv]  = (lane_head[lv] + 1) % JOB_SLOTS;
      lane_count[lv] = lane_count[lv] - 1;
   endfunction

   function automatic void lane_push(int lv, logic [JOB_ID_BITS-1:0] id);
      lane_slot[lv][(lane_head[lv] + lane_count[lv]) % JOB_SLOTS] = id;
      lane_count[lv] = lane_count[lv] + 1;
   endfunction

   // A lower level's front job that already ran loses its slice and goes
   // to the back of its own level when a higher level takes the tick.
   function automatic void requeue_partial(int lv);
      logic [JOB_ID_BITS-1:0] id;
      if (lane_count[lv] != 0) begin
         id = lane_front(lv);
         if (job_runs[id] != '0) begin
            job_runs[id] = '0;
            lane_pop(lv);
            lane_push(lv, id);
         end
      end
   endfunction

   function automatic sched_result_type schedule_step(logic [MODE_BITS-1:0] mode,
                                                      logic [JOB_ID_BITS-1:0] id,
                                                      logic [LENGTH_BITS-1:0] len);
      sched_result_type         res;
      int                       lv;
      logic [JOB_ID_BITS-1:0]   job;
      logic [CSR_DATA_BITS-1:0] slice;
      res = '0;
      res.status = mfq_pkg::STATUS_ADD_OK;
      if (mode == mfq_pkg::MODE_ADD) begin
         if (job_busy[id] || len == '0) begin
            res.status = mfq_pkg::STATUS_ADD_REJECT;
         end else begin
            job_busy[id] = 1'b1;
            job_need[id] = len;
            job_used[id] = '0;
            job_runs[id] = '0;
            lane_push(mfq_pkg::LEVEL_ONE, id);
         end
         return res;
      end
      // Highest non-empty level wins the tick
      if (lane_count[mfq_pkg::LEVEL_ONE] != 0) begin
         requeue_partial(mfq_pkg::LEVEL_TWO);
         requeue_partial(mfq_pkg::LEVEL_THREE);
         lv = mfq_pkg::LEVEL_ONE;
      end else if (lane_count[mfq_pkg::LEVEL_TWO] != 0) begin
         requeue_partial(mfq_pkg::LEVEL_THREE);
         lv = mfq_pkg::LEVEL_TWO;
      end else if (lane_count[mfq_pkg::LEVEL_THREE] != 0) begin
         lv = mfq_pkg::LEVEL_THREE;
      end else begin
         res.status = mfq_pkg::STATUS_TICK_IDLE;
         return res;
      end
      job = lane_front(lv);
      job_used[job] = job_used[job] + 1'b1;
      if (job_runs[job] != mfq_pkg::RUN_COUNT_MAX) job_runs[job] = job_runs[job] + 1'b1;
      res.finished = (job_used[job] == job_need[job]);
      if (res.finished) begin
         lane_pop(lv);
         job_busy[job] = 1'b0;
      end else if (lv == mfq_pkg::LEVEL_ONE) begin
         job_runs[job] = '0;
         lane_pop(mfq_pkg::LEVEL_ONE);
         lane_push(mfq_pkg::LEVEL_TWO, job);
      end else begin
         // quantum of zero behaves as one since the count is already >= 1
         slice = (lv == mfq_pkg::LEVEL_TWO) ? slice_two : slice_three;
         if (job_runs[job] >= slice) begin
            job_runs[job] = '0;
            lane_pop(lv);
            lane_push(mfq_pkg::LEVEL_THREE, job);
         end
      end
      res.status = mfq_pkg::STATUS_TICK_RAN;
      res.job    = job;
      res.level  = LEVEL_BITS'(lv);
      res.served = job_used[job];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Everything is driven at the falling edge; a word counts
   // as taken at the rising edge where valid and ready are both high, and
   // the shadow scheduler advances right there, in acceptance order.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [MODE_BITS-1:0] mode,
                            input logic [JOB_ID_BITS-1:0] id,
                            input logic [LENGTH_BITS-1:0] len);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid      = 1'b0;
         req_chan.mode       = MODE_BITS'($urandom);
         req_chan.job_id     = JOB_ID_BITS'($urandom);
         req_chan.run_length = LENGTH_BITS'($urandom);
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.mode       = mode;
      req_chan.job_id     = id;
      req_chan.run_length = len;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      due_results.insert(due_results.size(), schedule_step(mode, id, len));
      @(negedge clock);
   endtask

   task automatic add_job(input logic [JOB_ID_BITS-1:0] id,
                          input logic [LENGTH_BITS-1:0] len);
      send_word(mfq_pkg::MODE_ADD, id, len);
   endtask

   // job_id and run_length carry junk on a tick; the block must ignore them
   task automatic tick_once();
      send_word(mfq_pkg::MODE_TICK, JOB_ID_BITS'($urandom), LENGTH_BITS'($urandom));
   endtask

   // Drop valid, wait out every expected word and the pipeline behind it
   task automatic settle();
      req_chan.valid = 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_quantum(input logic index, input logic [CSR_DATA_BITS-1:0] value);
      settle();
      csr_write_en   = 1'b1;
      csr_index      = index;
      csr_write_data = value;
      if (index == mfq_pkg::CSR_QUANTUM_TWO) slice_two = value;
      else slice_three = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Mostly short jobs so ids recycle; now and then a long or full-width one
   function automatic logic [LENGTH_BITS-1:0] pick_length();
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) return LENGTH_BITS'($urandom_range(1, 65535));
      if (r < 10) return LENGTH_BITS'($urandom_range(9, 64));
      return LENGTH_BITS'($urandom_range(1, 8));
   endfunction

   // Well-formed traffic (ticks, adds on free ids) with a little noise:
   // adds on possibly busy ids and zero-length adds.
   task automatic random_word();
      int                     pick;
      int                     start;
      int                     k;
      int                     free_id;
      logic [JOB_ID_BITS-1:0] id;
      pick    = $urandom_range(0, 99);
      start   = $urandom_range(0, JOB_SLOTS - 1);
      free_id = -1;
      for (k = 0; k < JOB_SLOTS; k++) begin
         if (free_id < 0 && !job_busy[(start + k) % JOB_SLOTS]) free_id = (start + k) % JOB_SLOTS;
      end
      id = JOB_ID_BITS'($urandom);
      if (pick < 55 || (pick < 90 && free_id < 0)) begin
         tick_once();
      end else if (pick < 90) begin
         add_job(JOB_ID_BITS'(free_id), pick_length());
      end else if (pick < 95) begin
         add_job(id, pick_length());
      end else begin
         add_job(id, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------------

   // Hand-built sequence: idle tick, rejects, field extremes, finishes in levels
   // one and two, demotion into levels two and three, and rotation of a partly
   // served job in levels two and three caused by level one.
   task automatic test_directed_sequence();
      tick_once();                   // nothing queued: idle
      add_job(4'd0, 16'd1);
      add_job(4'd0, 16'd5);          // id busy
      add_job(4'd3, 16'd0);          // zero length
      add_job(4'd15, 16'hFFFF);      // longest job, top id
      add_job(4'd9, 16'd6);
      tick_once();                   // job 0 finishes in level one
      tick_once();                   // 15 drops to level two
      tick_once();                   // 9 drops to level two
      tick_once();                   // 15 partly served in level two
      add_job(4'd4, 16'd2);
      tick_once();                   // level one runs, 15 rotated in level two
      repeat (5) tick_once();        // demotions to level three, 4 finishes
      tick_once();
      add_job(4'd0, 16'd1);          // finished id reused
      tick_once();                   // level one runs, level three front rotated
      add_job(4'd2, 16'd3);
      tick_once();
      repeat (3) tick_once();
      add_job(4'd1, 16'd2);
      tick_once();
      tick_once();                   // level two runs, job 1 finishes
      settle();
   endtask

   // Widest quanta, then quanta lowered under a running job's count
   task automatic test_quantum_extremes();
      int free_id;
      int k;
      write_quantum(mfq_pkg::CSR_QUANTUM_TWO, 8'd255);
      write_quantum(mfq_pkg::CSR_QUANTUM_THREE, 8'd255);
      free_id = 0;
      for (k = JOB_SLOTS - 1; k >= 0; k--) if (!job_busy[k]) free_id = k;
      add_job(JOB_ID_BITS'(free_id), 16'd600);
      repeat (520) tick_once();      // full 255-tick stays in levels two and three
      write_quantum(mfq_pkg::CSR_QUANTUM_THREE, 8'd1);
      tick_once();
      tick_once();
      for (k = JOB_SLOTS - 1; k >= 0; k--) if (!job_busy[k]) free_id = k;
      add_job(JOB_ID_BITS'(free_id), 16'd50);
      repeat (3) tick_once();        // new job sits in level two with count 2
      write_quantum(mfq_pkg::CSR_QUANTUM_TWO, 8'd1);
      repeat (2) tick_once();
      settle();
   endtask

   // Random traffic under a spread of quantum pairs, zero among them
   task automatic test_random_settings();
      logic [CSR_DATA_BITS-1:0] two_set [5];
      logic [CSR_DATA_BITS-1:0] three_set [5];
      int                       s;
      two_set   = '{8'd1, 8'd0, 8'd3, 8'd255, mfq_pkg::QUANTUM_TWO_RESET};
      three_set = '{8'd1, 8'd0, 8'd2, 8'd1, mfq_pkg::QUANTUM_THREE_RESET};
      for (s = 0; s < 5; s++) begin
         write_quantum(mfq_pkg::CSR_QUANTUM_TWO, two_set[s]);
         write_quantum(mfq_pkg::CSR_QUANTUM_THREE, three_set[s]);
         repeat (24) random_word();
      end
      settle();
   endtask

   // Full rate on both channels
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      repeat (60) random_word();
      settle();
      gaps_on = 1'b1;
   endtask

   // Receiver holds off while words keep coming, so the input must stall
   task automatic test_output_hold();
      hold_request = 1'b1;
      repeat (30) random_word();
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Response side: random ready, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      bit hold_done;
      hold_done      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_chan.ready = !(gaps_on && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   task automatic report_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, actual status %0d",
                     $time, rsp_chan.status);
         end else begin
            head_result = due_results.pop_front();
            report_field("status", head_result.status, rsp_chan.status);
            report_field("ran_job", head_result.job, rsp_chan.ran_job);
            report_field("ran_level", head_result.level, rsp_chan.ran_level);
            report_field("job_finished", head_result.finished, rsp_chan.job_finished);
            report_field("served_time", head_result.served, rsp_chan.served_time);
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      int k;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = mfq_pkg::MODE_ADD;
      req_chan.job_id     = '0;
      req_chan.run_length = '0;
      csr_write_en        = 1'b0;
      csr_index           = mfq_pkg::CSR_QUANTUM_TWO;
      csr_write_data      = '0;
      gaps_on             = 1'b1;
      hold_request        = 1'b0;
      slice_two           = mfq_pkg::QUANTUM_TWO_RESET;
      slice_three         = mfq_pkg::QUANTUM_THREE_RESET;
      for (k = 0; k < 3; k++) begin
         lane_head[k]  = 0;
         lane_count[k] = 0;
      end
      for (k = 0; k < JOB_SLOTS; k++) begin
         job_busy[k] = 1'b0;
         job_need[k] = '0;
         job_used[k] = '0;
         job_runs[k] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_sequence();
      test_quantum_extremes();
      test_random_settings();
      test_back_to_back();
      test_output_hold();
      settle();

      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
